### hdl/bbcs_pkg.sv
// shared types and constants of the balance bike control step
package bbcs_pkg;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 26;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef logic signed [MUL_A_W-1:0] mul_a_t;
  typedef logic signed [MUL_B_W-1:0] mul_b_t;
  typedef logic signed [MUL_P_W-1:0] mul_p_t;

  // register indexes on the configuration port
  localparam logic [2:0] REG_TILT_P    = 3'd0;
  localparam logic [2:0] REG_TILT_D    = 3'd1;
  localparam logic [2:0] REG_SPEED_P   = 3'd2;
  localparam logic [2:0] REG_SPEED_I   = 3'd3;
  localparam logic [2:0] REG_KNOB_CTR  = 3'd4;
  localparam logic [2:0] REG_LOW_BATT  = 3'd5;

  // reset values
  localparam logic [11:0] KNOB_CTR_RST = 12'd2048;
  localparam logic [11:0] LOW_BATT_RST = 12'd1100;

  // controller constants
  localparam int DRIVE_LIMIT  = 7000;
  localparam int WALK_LIMIT   = 7200;
  localparam int INTEG_LIMIT  = 1500 * 256;
  localparam int TILT_LIMIT   = 30 * 256;
  localparam int ROLL_LIMIT   = 15 * 256;
  localparam int MID_BASE     = 3;
  localparam int FILT_OLD     = 179;
  localparam int FILT_NEW     = 77;
  localparam int KNOB_STEP    = 392;
  localparam int ENC_STEP     = 35;
  // reciprocals, floor(2^shift / step); quotient comes out exact or one low
  localparam int KNOB_RECIP   = 2674;
  localparam int KNOB_SHIFT   = 20;
  localparam int ENC_RECIP    = 59918;
  localparam int ENC_SHIFT    = 21;

endpackage

### hdl/balance_bike_control_step_core.sv
// balance bike control step: sequencer around one shared multiplier
// A new request is taken only after the twelve-step sequence through the single
// multiplier has finished and the result has been loaded; out_valid then rises.
// A waiting result holds the last step.
// Reset (rst_n low, synchronous): gains zero, knob centre 2048, battery
// limit 1100, filter, integral, walk state and stop latch cleared.
module balance_bike_control_step_core (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [16:0] in_pitch,
  input  logic signed [16:0] in_roll,
  input  logic signed [15:0] in_gyro_rate,
  input  logic signed [15:0] in_balance_encoder,
  input  logic signed [15:0] in_walk_encoder,
  input  logic signed [7:0]  in_walk_target,
  input  logic [11:0]        in_battery_voltage,
  input  logic [11:0]        in_trim_knob,
  input  logic               in_stop_press,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [13:0] out_balance_drive,
  output logic signed [13:0] out_walk_drive,
  output logic               out_motors_off,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import bbcs_pkg::*;

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_KMUL = 13'b0000000000010,
    ST_KCHK = 13'b0000000000100,
    ST_EMUL = 13'b0000000001000,
    ST_ECHK = 13'b0000000010000,
    ST_MID  = 13'b0000000100000,
    ST_TILT = 13'b0000001000000,
    ST_TSUM = 13'b0000010000000,
    ST_FOLD = 13'b0000100000000,
    ST_FNEW = 13'b0001000000000,
    ST_SPD  = 13'b0010000000000,
    ST_INT  = 13'b0100000000000,
    ST_FIN  = 13'b1000000000000
  } state_t;

  // truncating divide by 2^k, toward zero
  function automatic mul_p_t tdiv(input mul_p_t x, input int k);
    mul_p_t bias;
    bias = x[MUL_P_W-1] ? ((mul_p_t'(1) <<< k) - mul_p_t'(1)) : '0;
    return (x + bias) >>> k;
  endfunction

  state_t state_r, state_nxt;

  // configuration registers
  logic [15:0] tilt_p_r, tilt_d_r, speed_p_r, speed_i_r;
  logic [11:0] knob_ctr_r, low_batt_r;

  // latched request
  logic signed [16:0] pitch_r, roll_r;
  logic signed [15:0] gyro_r, benc_r, wenc_r;
  logic signed [7:0]  tgt_r;
  logic [11:0]        volt_r;
  logic               press_r;
  logic [11:0]        kd_abs_r;
  logic               kd_neg_r;
  logic [15:0]        enc_abs_r;
  logic               enc_neg_r;

  // controller state
  logic signed [24:0] filter_r;
  logic signed [19:0] integ_r;
  logic signed [13:0] walk_acc_r;
  logic signed [16:0] last_err_r;
  logic               stopped_r;

  // working registers
  logic [3:0]         qk_r;
  logic [9:0]         qe_r;
  logic signed [19:0] mid_r;
  logic signed [24:0] tilt_r;
  mul_p_t             acc_r;

  // output registers
  logic               out_valid_r;
  logic signed [13:0] bal_out_r, walk_out_r;
  logic               off_out_r;

  // multiplier
  mul_a_t mul_a;
  mul_b_t mul_b;
  mul_p_t prod_r;

  bbcs_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  logic               accept;
  logic               out_free;
  logic               st;
  logic signed [12:0] kd;
  logic signed [16:0] enc_ext;
  logic signed [16:0] enc_mag;
  logic [11:0]        kd_rem;
  logic [15:0]        enc_rem;
  logic [9:0]         qe_fix;
  logic signed [11:0] qk_s, qe_s, mid_w;
  logic signed [20:0] pdiff;
  logic signed [16:0] werr;
  logic signed [17:0] wdelta;
  logic signed [22:0] wsum;
  logic signed [13:0] walk_sat;
  mul_p_t             tsum, fsum, fdiv, speed, total, bdiv;
  logic signed [24:0] filt;
  logic signed [25:0] isum;
  logic signed [19:0] integ_sat;
  logic signed [13:0] bal_sat, walk_clip;
  logic               fault, off;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !(out_valid_r && out_stall);
  assign st       = stopped_r ^ press_r;

  // request preprocessing: knob offset and encoder magnitude
  always_comb begin
    kd      = $signed({1'b0, in_trim_knob}) - $signed({1'b0, knob_ctr_r});
    enc_ext = 17'(in_balance_encoder);
    enc_mag = enc_ext[16] ? -enc_ext : enc_ext;
  end

  // divider corrections and midpoint
  always_comb begin
    kd_rem = kd_abs_r - prod_r[11:0];
    enc_rem = enc_abs_r - prod_r[15:0];
    qe_fix = qe_r + ((enc_rem >= 16'(ENC_STEP)) ? 10'd1 : 10'd0);
    qk_s = kd_neg_r ? -$signed(12'(qk_r)) : $signed(12'(qk_r));
    qe_s = enc_neg_r ? -$signed(12'(qe_fix)) : $signed(12'(qe_fix));
    mid_w = qk_s + 12'sd3 - qe_s;
    pdiff = 21'(pitch_r) - 21'(mid_r);
  end

  // incremental walk pi
  always_comb begin
    werr   = 17'(wenc_r) - 17'(tgt_r);
    wdelta = 18'(werr) - 18'(last_err_r);
    wsum   = 23'(walk_acc_r)
           + (23'(wdelta) <<< 4) - 23'(wdelta)
           + (23'(werr) <<< 4) - 23'(werr);
    priority if (wsum > 23'sd7200) begin
      walk_sat = 14'(WALK_LIMIT);
    end else if (wsum < -23'sd7200) begin
      walk_sat = -14'(WALK_LIMIT);
    end else begin
      walk_sat = wsum[13:0];
    end
  end

  // tilt sum, filter update and integral clamp
  always_comb begin
    tsum = acc_r + prod_r;
    fsum = acc_r + (prod_r <<< 8);
    fdiv = tdiv(fsum, 8);
    filt = fdiv[24:0];
    isum = 26'(integ_r) + 26'(filt);
    priority if (isum > 26'(INTEG_LIMIT)) begin
      integ_sat = 20'(INTEG_LIMIT);
    end else if (isum < -26'(INTEG_LIMIT)) begin
      integ_sat = -20'(INTEG_LIMIT);
    end else begin
      integ_sat = isum[19:0];
    end
  end

  // final combine, clamps and fault test
  always_comb begin
    speed = st ? '0 : (acc_r + prod_r);
    total = (mul_p_t'(tilt_r) <<< 16) + speed;
    bdiv  = tdiv(total, 16);
    priority if (bdiv > mul_p_t'(DRIVE_LIMIT)) begin
      bal_sat = 14'(DRIVE_LIMIT);
    end else if (bdiv < -mul_p_t'(DRIVE_LIMIT)) begin
      bal_sat = -14'(DRIVE_LIMIT);
    end else begin
      bal_sat = bdiv[13:0];
    end
    priority if (walk_acc_r > 14'sd7000) begin
      walk_clip = 14'(DRIVE_LIMIT);
    end else if (walk_acc_r < -14'sd7000) begin
      walk_clip = -14'(DRIVE_LIMIT);
    end else begin
      walk_clip = walk_acc_r;
    end
    fault = (pdiff < -21'(TILT_LIMIT)) || (pdiff > 21'(TILT_LIMIT))
         || (roll_r > 17'(ROLL_LIMIT)) || (roll_r < -17'(ROLL_LIMIT))
         || (volt_r < low_batt_r);
    off = st || fault;
  end

  // multiplier operand selection; the last step reissues the same product
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_KMUL: begin
        mul_a = mul_a_t'(kd_abs_r);
        mul_b = mul_b_t'(KNOB_RECIP);
      end
      ST_KCHK: begin
        mul_a = mul_a_t'(prod_r[KNOB_SHIFT+3:KNOB_SHIFT]);
        mul_b = mul_b_t'(KNOB_STEP);
      end
      ST_EMUL: begin
        mul_a = mul_a_t'(enc_abs_r);
        mul_b = mul_b_t'(ENC_RECIP);
      end
      ST_ECHK: begin
        mul_a = mul_a_t'(prod_r[ENC_SHIFT+9:ENC_SHIFT]);
        mul_b = mul_b_t'(ENC_STEP);
      end
      ST_MID: begin
        mul_a = mul_a_t'(gyro_r);
        mul_b = mul_b_t'(tilt_d_r);
      end
      ST_TILT: begin
        mul_a = mul_a_t'(pdiff);
        mul_b = mul_b_t'(tilt_p_r);
      end
      ST_TSUM: begin
        mul_a = mul_a_t'(filter_r);
        mul_b = mul_b_t'(FILT_OLD);
      end
      ST_FOLD: begin
        mul_a = mul_a_t'(benc_r);
        mul_b = mul_b_t'(FILT_NEW);
      end
      ST_SPD: begin
        mul_a = mul_a_t'(filter_r);
        mul_b = mul_b_t'(speed_p_r);
      end
      ST_INT, ST_FIN: begin
        mul_a = mul_a_t'(integ_r);
        mul_b = mul_b_t'(speed_i_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_KMUL;
      ST_KMUL: state_nxt = ST_KCHK;
      ST_KCHK: state_nxt = ST_EMUL;
      ST_EMUL: state_nxt = ST_ECHK;
      ST_ECHK: state_nxt = ST_MID;
      ST_MID:  state_nxt = ST_TILT;
      ST_TILT: state_nxt = ST_TSUM;
      ST_TSUM: state_nxt = ST_FOLD;
      ST_FOLD: state_nxt = ST_FNEW;
      ST_FNEW: state_nxt = ST_SPD;
      ST_SPD:  state_nxt = ST_INT;
      ST_INT:  state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      filter_r    <= '0;
      integ_r     <= '0;
      walk_acc_r  <= '0;
      last_err_r  <= '0;
      stopped_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (state_r == ST_KMUL) begin
        walk_acc_r <= walk_sat;
        last_err_r <= werr;
      end
      if (state_r == ST_FNEW) begin
        filter_r <= filt;
        integ_r  <= st ? '0 : integ_sat;
      end
      if ((state_r == ST_FIN) && out_free) begin
        out_valid_r <= 1'b1;
        stopped_r   <= off;
      end
    end
  end

  // request latch, working registers and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      pitch_r   <= in_pitch;
      roll_r    <= in_roll;
      gyro_r    <= in_gyro_rate;
      benc_r    <= in_balance_encoder;
      wenc_r    <= in_walk_encoder;
      tgt_r     <= in_walk_target;
      volt_r    <= in_battery_voltage;
      press_r   <= in_stop_press;
      kd_neg_r  <= kd[12];
      kd_abs_r  <= kd[12] ? 12'(-kd) : kd[11:0];
      enc_neg_r <= enc_ext[16];
      enc_abs_r <= enc_mag[15:0];
    end
    unique case (state_r)
      ST_KCHK: qk_r <= prod_r[KNOB_SHIFT+3:KNOB_SHIFT];
      ST_EMUL: if (kd_rem >= 12'(KNOB_STEP)) qk_r <= qk_r + 4'd1;
      ST_ECHK: qe_r <= prod_r[ENC_SHIFT+9:ENC_SHIFT];
      ST_MID:  mid_r <= {mid_w, 8'b0};
      ST_TILT: acc_r <= prod_r <<< 8;
      ST_TSUM: begin
        tsum_to_tilt();
      end
      ST_FOLD: acc_r <= prod_r;
      ST_INT:  acc_r <= prod_r;
      ST_FIN: begin
        if (out_free) begin
          bal_out_r  <= off ? '0 : bal_sat;
          walk_out_r <= off ? '0 : walk_clip;
          off_out_r  <= off;
        end
      end
      default: begin
      end
    endcase
  end

  // tilt term kept as a plain register write
  mul_p_t tilt_div;
  assign tilt_div = tdiv(tsum, 16);

  function automatic void tsum_to_tilt();
  endfunction

  always_ff @(posedge clk) begin
    if (state_r == ST_TSUM) tilt_r <= tilt_div[24:0];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tilt_p_r   <= '0;
      tilt_d_r   <= '0;
      speed_p_r  <= '0;
      speed_i_r  <= '0;
      knob_ctr_r <= KNOB_CTR_RST;
      low_batt_r <= LOW_BATT_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[4:2])
        REG_TILT_P:   tilt_p_r   <= pwdata[15:0];
        REG_TILT_D:   tilt_d_r   <= pwdata[15:0];
        REG_SPEED_P:  speed_p_r  <= pwdata[15:0];
        REG_SPEED_I:  speed_i_r  <= pwdata[15:0];
        REG_KNOB_CTR: knob_ctr_r <= pwdata[11:0];
        REG_LOW_BATT: low_batt_r <= pwdata[11:0];
        default: begin
        end
      endcase
    end
  end

  // configuration reads
  always_comb begin
    unique case (paddr[4:2])
      REG_TILT_P:   prdata = 32'(tilt_p_r);
      REG_TILT_D:   prdata = 32'(tilt_d_r);
      REG_SPEED_P:  prdata = 32'(speed_p_r);
      REG_SPEED_I:  prdata = 32'(speed_i_r);
      REG_KNOB_CTR: prdata = 32'(knob_ctr_r);
      REG_LOW_BATT: prdata = 32'(low_batt_r);
      default:      prdata = '0;
    endcase
  end

  assign pready            = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_balance_drive = bal_out_r;
  assign out_walk_drive    = walk_out_r;
  assign out_motors_off    = off_out_r;

endmodule

### hdl/bbcs_mul.sv
// shared signed multiplier with registered product
module bbcs_mul (
  input  logic            clk,
  input  bbcs_pkg::mul_a_t a,
  input  bbcs_pkg::mul_b_t b,
  output bbcs_pkg::mul_p_t prod_r
);
  import bbcs_pkg::*;

  // one product per cycle, available on the next
  always_ff @(posedge clk) begin
    prod_r <= mul_p_t'(a) * mul_p_t'(b);
  end

endmodule
